// ----- sv/dtl_pkg.sv -----
package dtl_pkg;

   localparam int REQ_W  = 3;
   localparam int VID_W  = 4;
   localparam int WIN_W  = 16;
   localparam int STAT_W = 2;
   localparam int POS_W  = 4;
   localparam int LEN_W  = 20;
   localparam int CNT_W  = 5;
   localparam int VC_W   = 5;

   localparam logic [VC_W-1:0]  VC_RESET = 5'd16;
   localparam logic [LEN_W-1:0] LEN_MAX  = 20'hFFFFF;

   localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SORT     = 3'd2;
   localparam logic [REQ_W-1:0] REQ_PATH     = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PATH_SRC = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_CYCLE  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_DEG,
      ST_PICK,
      ST_DEC,
      ST_LP,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VID_W-1:0]  vertex;
      logic [POS_W-1:0]  position;
      logic [LEN_W-1:0]  path_length;
      logic              is_last;
   } rsp_type;

endpackage

// ----- sv/dtl_ram.sv -----
module dtl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- sv/dtl_relax.sv -----
module dtl_relax #(
   parameter int DW = 20,
   parameter int WB = 16
) (
   input  logic [DW-1:0] base,
   input  logic [WB-1:0] w,
   input  logic [DW-1:0] old_dist,
   input  logic          old_ok,
   input  logic [DW-1:0] cur_max,
   output logic [DW-1:0] next_dist,
   output logic [DW-1:0] next_max
);

   logic [DW-1:0] sum;

   always_comb begin
      sum       = base + DW'(w);
      next_dist = (!old_ok || sum > old_dist) ? sum : old_dist;
      next_max  = (next_dist > cur_max) ? next_dist : cur_max;
   end

endmodule

// ----- sv/dag_topo_sort_longest_path.sv -----
// Weighted DAG engine: edge add/remove, Kahn topological sort and longest path
// over an adjacency matrix held in one RAM. After reset the RAM is cleared one
// entry a cycle while req_ready stays low. Add and remove read the edge entry,
// then write it unless rejected. A sort walks the matrix once for in-degrees,
// then for each ordered vertex picks it and decrements along its row;
// longest-path requests add one more relaxation pass over the matrix. Each walk
// step is one matrix RAM read, and the relaxation pass feeds it to a single
// add/compare unit, so run time is set by that read port. One request is in
// flight at a time; results wait in an output register until taken.
module dag_topo_sort_longest_path #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dtl_pkg::REQ_W-1:0]   req_type,
   input  logic [dtl_pkg::VID_W-1:0]   req_src_vertex,
   input  logic [dtl_pkg::VID_W-1:0]   req_dst_vertex,
   input  logic [dtl_pkg::WIN_W-1:0]   req_weight,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dtl_pkg::STAT_W-1:0]  rsp_status,
   output logic [dtl_pkg::VID_W-1:0]   rsp_vertex,
   output logic [dtl_pkg::POS_W-1:0]   rsp_position,
   output logic [dtl_pkg::LEN_W-1:0]   rsp_path_length,
   output logic                        rsp_is_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dtl_pkg::VC_W-1:0]    csr_vertex_count
);
   import dtl_pkg::*;

   localparam int CAP   = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int VB    = $clog2(CAP);
   localparam int AW    = 2 * VB;
   localparam int DEPTH = 1 << AW;
   localparam int DW    = WEIGHT_BITS + VB;
   localparam int SW    = DW + LEN_W;

   state_type state_ff, state_in, ret_ff, ret_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [VC_W-1:0] vc_ff, vc_in;
   logic [AW-1:0]   clr_ff, clr_in;

   logic [REQ_W-1:0]       rq_ff, rq_in;
   logic [VID_W-1:0]       u_ff, u_in, v_ff, v_in;
   logic [WEIGHT_BITS-1:0] wt_ff, wt_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [VB-1:0]    pick_ff, pick_in;

   logic          wk_act_ff, wk_act_in, pend_ff, pend_in;
   logic [VB-1:0] wr_ff, wr_in, wc_ff, wc_in, pc_ff, pc_in, pu_ff, pu_in;

   logic [VB-1:0] indeg_ff [0:CAP-1];
   logic [VB-1:0] indeg_in [0:CAP-1];
   logic          taken_ff [0:CAP-1];
   logic          taken_in [0:CAP-1];
   logic [VB-1:0] order_ff [0:CAP-1];
   logic [VB-1:0] order_in [0:CAP-1];
   logic [DW-1:0] best_ff  [0:CAP-1];
   logic [DW-1:0] best_in  [0:CAP-1];
   logic          reach_ff [0:CAP-1];
   logic          reach_in [0:CAP-1];
   logic [DW-1:0] ans_ff, ans_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr, edge_addr;
   logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;

   logic [CNT_W-1:0] n_live, n_last;
   logic [VB-1:0]    row_addr;
   logic             c_last, r_last, walk_done;
   logic             pick_found, last_v, bad_e, bad_w;
   logic [VB-1:0]    pick_idx;
   logic [WEIGHT_BITS+WIN_W-1:0] w_ext;
   logic [DW-1:0]    rx_dist, rx_max;
   logic [SW-1:0]    ans_wide;
   logic [LEN_W-1:0] ans_sat;

   dtl_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_mat (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dtl_relax #(.DW(DW), .WB(WEIGHT_BITS)) u_relax (
      .base      (best_ff[pu_ff]),
      .w         (ram_rdata),
      .old_dist  (best_ff[pc_ff]),
      .old_ok    (reach_ff[pc_ff]),
      .cur_max   (ans_ff),
      .next_dist (rx_dist),
      .next_max  (rx_max)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_vertex      = rsp_ff.vertex;
   assign rsp_position    = rsp_ff.position;
   assign rsp_path_length = rsp_ff.path_length;
   assign rsp_is_last     = rsp_ff.is_last;

   always_comb begin
      n_live = (vc_ff == '0) ? CNT_W'(1) :
               (vc_ff > VC_W'(CAP)) ? CNT_W'(CAP) : CNT_W'(vc_ff);
      n_last    = n_live - CNT_W'(1);
      w_ext     = {{WEIGHT_BITS{1'b0}}, req_weight};
      edge_addr = {u_ff[VB-1:0], v_ff[VB-1:0]};
      unique case (state_ff)
         ST_DEC:  row_addr = pick_ff;
         ST_LP:   row_addr = order_ff[wr_ff];
         default: row_addr = wr_ff;
      endcase
      ram_raddr = (state_ff == ST_EDGE_RD) ? edge_addr : {row_addr, wc_ff};
      c_last    = (CNT_W'(wc_ff) == n_last);
      r_last    = (CNT_W'(wr_ff) == n_last);
      walk_done = !wk_act_ff && !pend_ff;
      last_v    = ((count_ff + CNT_W'(1)) == n_live);
      bad_e     = (req_src_vertex == req_dst_vertex) ||
                  (CNT_W'(req_src_vertex) >= n_live) || (CNT_W'(req_dst_vertex) >= n_live);
      bad_w     = (rq_ff == REQ_ADD) ? (wt_ff == '0 || ram_rdata != '0) : (ram_rdata == '0);
      ans_wide  = SW'(ans_ff);
      ans_sat   = (ans_wide > SW'(LEN_MAX)) ? LEN_MAX : LEN_W'(ans_ff);
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (CNT_W'(i) < n_live && !taken_ff[i] && indeg_ff[i] == '0) begin
            pick_found = 1'b1;
            pick_idx   = VB'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      vc_in        = csr_valid ? csr_vertex_count : vc_ff;
      clr_in       = clr_ff;
      rq_in        = rq_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      wt_in        = wt_ff;
      count_in     = count_ff;
      pick_in      = pick_ff;
      wk_act_in    = wk_act_ff;
      wr_in        = wr_ff;
      wc_in        = wc_ff;
      pend_in      = 1'b0;
      pc_in        = wc_ff;
      pu_in        = row_addr;
      indeg_in     = indeg_ff;
      taken_in     = taken_ff;
      order_in     = order_ff;
      best_in      = best_ff;
      reach_in     = reach_ff;
      ans_in       = ans_ff;
      ram_we       = 1'b0;
      ram_waddr    = edge_addr;
      ram_wdata    = wt_ff;

      if ((state_ff == ST_DEG || state_ff == ST_DEC || state_ff == ST_LP) && wk_act_ff) begin
         pend_in = 1'b1;
         if (c_last) begin
            wc_in = '0;
            if (state_ff == ST_DEC || r_last) begin
               wk_act_in = 1'b0;
            end else begin
               wr_in = wr_ff + VB'(1);
            end
         end else begin
            wc_in = wc_ff + VB'(1);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rq_in = req_type;
               u_in  = req_src_vertex;
               v_in  = req_dst_vertex;
               wt_in = w_ext[WEIGHT_BITS-1:0];
               rsp_in = '{status: STAT_REJECT, vertex: '0, position: '0,
                          path_length: '0, is_last: 1'b1};
               ret_in = ST_IDLE;
               case (req_type) inside
                  REQ_ADD, REQ_REMOVE: begin
                     if (bad_e) begin
                        rsp_valid_in = 1'b1;
                        state_in     = ST_SEND;
                     end else begin
                        state_in = ST_EDGE_RD;
                     end
                  end
                  REQ_SORT, REQ_PATH, REQ_PATH_SRC: begin
                     if (req_type == REQ_PATH_SRC && CNT_W'(req_src_vertex) >= n_live) begin
                        rsp_valid_in = 1'b1;
                        state_in     = ST_SEND;
                     end else begin
                        count_in  = '0;
                        wk_act_in = 1'b1;
                        wr_in     = '0;
                        wc_in     = '0;
                        for (int i = 0; i < CAP; i++) begin
                           taken_in[i] = 1'b0;
                           indeg_in[i] = '0;
                        end
                        state_in = ST_DEG;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_SEND;
                  end
               endcase
            end
         end
         ST_EDGE_RD: begin
            state_in = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            if (!bad_w) begin
               ram_we    = 1'b1;
               ram_wdata = (rq_ff == REQ_ADD) ? wt_ff : '0;
            end
            rsp_in = '{status: bad_w ? STAT_REJECT : STAT_OK, vertex: '0, position: '0,
                       path_length: '0, is_last: 1'b1};
            rsp_valid_in = 1'b1;
            ret_in       = ST_IDLE;
            state_in     = ST_SEND;
         end
         ST_DEG: begin
            if (pend_ff && ram_rdata != '0) begin
               indeg_in[pc_ff] = indeg_ff[pc_ff] + VB'(1);
            end
            if (walk_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (pick_found) begin
               taken_in[pick_idx]           = 1'b1;
               order_in[count_ff[VB-1:0]]   = pick_idx;
               count_in                     = count_ff + CNT_W'(1);
               pick_in                      = pick_idx;
               wk_act_in                    = 1'b1;
               wr_in                        = '0;
               wc_in                        = '0;
               if (rq_ff == REQ_SORT) begin
                  rsp_in = '{status: STAT_OK, vertex: VID_W'(pick_idx),
                             position: POS_W'(count_ff), path_length: '0, is_last: last_v};
                  rsp_valid_in = 1'b1;
                  ret_in       = last_v ? ST_IDLE : ST_DEC;
                  state_in     = ST_SEND;
               end else if (last_v) begin
                  ans_in = '0;
                  for (int i = 0; i < CAP; i++) begin
                     best_in[i]  = '0;
                     reach_in[i] = (rq_ff == REQ_PATH) || (u_ff == VID_W'(i));
                  end
                  state_in = ST_LP;
               end else begin
                  state_in = ST_DEC;
               end
            end else begin
               rsp_in = '{status: STAT_CYCLE, vertex: '0,
                          position: (rq_ff == REQ_SORT) ? POS_W'(count_ff) : '0,
                          path_length: '0, is_last: 1'b1};
               rsp_valid_in = 1'b1;
               ret_in       = ST_IDLE;
               state_in     = ST_SEND;
            end
         end
         ST_DEC: begin
            if (pend_ff && ram_rdata != '0 && indeg_ff[pc_ff] != '0) begin
               indeg_in[pc_ff] = indeg_ff[pc_ff] - VB'(1);
            end
            if (walk_done) begin
               state_in = ST_PICK;
            end
         end
         ST_LP: begin
            if (pend_ff && ram_rdata != '0 && reach_ff[pu_ff]) begin
               best_in[pc_ff]  = rx_dist;
               reach_in[pc_ff] = 1'b1;
               ans_in          = rx_max;
            end
            if (walk_done) begin
               rsp_in = '{status: STAT_OK, vertex: '0, position: '0,
                          path_length: ans_sat, is_last: 1'b1};
               rsp_valid_in = 1'b1;
               ret_in       = ST_IDLE;
               state_in     = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vc_ff        <= VC_RESET;
         clr_ff       <= '0;
         wk_act_ff    <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         vc_ff        <= vc_in;
         clr_ff       <= clr_in;
         wk_act_ff    <= wk_act_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      rq_ff    <= rq_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      wt_ff    <= wt_in;
      count_ff <= count_in;
      pick_ff  <= pick_in;
      wr_ff    <= wr_in;
      wc_ff    <= wc_in;
      pc_ff    <= pc_in;
      pu_ff    <= pu_in;
      indeg_ff <= indeg_in;
      taken_ff <= taken_in;
      order_ff <= order_in;
      best_ff  <= best_in;
      reach_ff <= reach_in;
      ans_ff   <= ans_in;
   end

endmodule

// ----- sv/dtl_checker.sv -----
module dtl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dtl_pkg::STAT_W-1:0] rsp_status,
   input logic                       rsp_is_last
);
   import dtl_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a request transfer");

   a_more_after_partial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=> !req_ready)
      else $error("idle before the final result");

   a_cycle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_CYCLE |-> rsp_is_last)
      else $error("cycle status not final");

endmodule

bind dag_topo_sort_longest_path dtl_checker u_dtl_checker (.*);

// ----- dv/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtl_pkg::*;

   localparam logic [REQ_W-1:0] REQ_BAD_LO  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_BAD_MID = 3'd6;
   localparam logic [REQ_W-1:0] REQ_BAD_HI  = 3'd7;
   localparam int WDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [REQ_W-1:0] req_type = '0;
   logic [VID_W-1:0] req_src_vertex = '0;
   logic [VID_W-1:0] req_dst_vertex = '0;
   logic [WIN_W-1:0] req_weight = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [VID_W-1:0] rsp_vertex;
   logic [POS_W-1:0] rsp_position;
   logic [LEN_W-1:0] rsp_path_length;
   logic rsp_is_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VC_W-1:0] csr_vertex_count = '0;

   always #4 clock = ~clock;

   dag_topo_sort_longest_path u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_src_vertex(req_src_vertex), .req_dst_vertex(req_dst_vertex),
      .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_vertex(rsp_vertex), .rsp_position(rsp_position),
      .rsp_path_length(rsp_path_length), .rsp_is_last(rsp_is_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_vertex_count(csr_vertex_count)
   );

   // graph shadow
   logic [WIN_W-1:0] graph_wt [16][16];
   int unsigned link_total;
   logic [VC_W-1:0] vcount;
   rsp_type pending_rsp[$];
   int err_count = 0;
   int hold_cycles = 0;
   int wdog = 0;
   bit fast_side = 1'b0;

   task automatic report(string what, rsp_type got, rsp_type want);
      $display("mismatch %s: got st=%0d v=%0d p=%0d len=%0d last=%0d %s",
               what, got.status, got.vertex, got.position, got.path_length, got.is_last,
               $sformatf("want st=%0d v=%0d p=%0d len=%0d last=%0d",
                         want.status, want.vertex, want.position, want.path_length,
                         want.is_last));
      err_count++;
   endtask

   function automatic int live_count();
      if (vcount < 1) return 1;
      if (vcount > 16) return 16;
      return vcount;
   endfunction

   function automatic int kahn_order(int n, output int ord[16]);
      int deg[16];
      bit taken[16];
      int cnt, pick;
      cnt = 0;
      for (int v = 0; v < n; v++) begin
         deg[v] = 0;
         taken[v] = 0;
         for (int i = 0; i < n; i++) if (graph_wt[i][v] != 0) deg[v]++;
      end
      while (cnt < n) begin
         pick = n;
         for (int i = 0; i < n; i++)
            if (!taken[i] && deg[i] == 0) begin
               pick = i;
               break;
            end
         if (pick == n) break;
         ord[cnt] = pick;
         taken[pick] = 1;
         cnt++;
         for (int v = 0; v < n; v++)
            if (graph_wt[pick][v] != 0 && deg[v] > 0) deg[v]--;
      end
      return cnt;
   endfunction

   function automatic logic [LEN_W-1:0] longest_sum(int n, bit from_src, int src,
                                                    int ord[16]);
      longint dist_tab[16];
      bit reach[16];
      longint best, d;
      int u;
      best = 0;
      for (int v = 0; v < n; v++) begin
         dist_tab[v] = 0;
         reach[v] = !from_src || v == src;
      end
      for (int k = 0; k < n; k++) begin
         u = ord[k];
         if (!reach[u]) continue;
         for (int v = 0; v < n; v++) begin
            if (graph_wt[u][v] == 0) continue;
            d = dist_tab[u] + graph_wt[u][v];
            if (!reach[v] || d > dist_tab[v]) begin
               dist_tab[v] = d;
               reach[v] = 1;
            end
            if (dist_tab[v] > best) best = dist_tab[v];
         end
      end
      if (best > LEN_MAX) best = LEN_MAX;
      return best[LEN_W-1:0];
   endfunction

   function automatic rsp_type mk(logic [STAT_W-1:0] st, int vx, int pos,
                                  logic [LEN_W-1:0] len, bit last);
      rsp_type r;
      r.status = st;
      r.vertex = vx[VID_W-1:0];
      r.position = pos[POS_W-1:0];
      r.path_length = len;
      r.is_last = last;
      return r;
   endfunction

   task automatic predict_graph(logic [REQ_W-1:0] op, int u, int v, logic [WIN_W-1:0] w);
      int n, cnt;
      int ord[16];
      bit bad, has_out;
      n = live_count();
      case (op) inside
         REQ_ADD, REQ_REMOVE: begin
            bad = (u == v) || u >= n || v >= n;
            if (!bad) begin
               if (op == REQ_ADD) begin
                  if (w == 0 || graph_wt[u][v] != 0) bad = 1;
                  else begin
                     graph_wt[u][v] = w;
                     link_total++;
                  end
               end else begin
                  if (graph_wt[u][v] == 0) bad = 1;
                  else begin
                     graph_wt[u][v] = 0;
                     if (link_total > 0) link_total--;
                  end
               end
            end
            pending_rsp.push_back(mk(bad ? STAT_REJECT : STAT_OK, 0, 0, 0, 1));
         end
         REQ_SORT: begin
            cnt = kahn_order(n, ord);
            for (int k = 0; k < cnt; k++)
               pending_rsp.push_back(mk(STAT_OK, ord[k], k, 0, cnt == n && k + 1 == cnt));
            if (cnt < n) pending_rsp.push_back(mk(STAT_CYCLE, 0, cnt, 0, 1));
         end
         REQ_PATH: begin
            if (kahn_order(n, ord) != n) pending_rsp.push_back(mk(STAT_CYCLE, 0, 0, 0, 1));
            else if (link_total == 0) pending_rsp.push_back(mk(STAT_OK, 0, 0, 0, 1));
            else pending_rsp.push_back(mk(STAT_OK, 0, 0, longest_sum(n, 0, 0, ord), 1));
         end
         REQ_PATH_SRC: begin
            if (u >= n) pending_rsp.push_back(mk(STAT_REJECT, 0, 0, 0, 1));
            else if (kahn_order(n, ord) != n) pending_rsp.push_back(mk(STAT_CYCLE, 0, 0, 0, 1));
            else begin
               has_out = 0;
               for (int k = 0; k < n; k++) if (graph_wt[u][k] != 0) has_out = 1;
               pending_rsp.push_back(mk(STAT_OK, 0, 0,
                                        has_out ? longest_sum(n, 1, u, ord) : '0, 1));
            end
         end
         default: pending_rsp.push_back(mk(STAT_REJECT, 0, 0, 0, 1));
      endcase
   endtask

   function automatic int pick_gap();
      if (fast_side) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2);
   endfunction

   task automatic send_req(logic [REQ_W-1:0] op, int u, int v, logic [WIN_W-1:0] w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_src_vertex <= u[VID_W-1:0];
      req_dst_vertex <= v[VID_W-1:0];
      req_weight <= w;
      do @(posedge clock); while (!req_ready);
      predict_graph(op, u, v, w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [VC_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_vertex_count <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vcount = val;
      @(posedge clock);
   endtask

   // receiver with random stalls and forced hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_type got;
            got = '{rsp_status, rsp_vertex, rsp_position, rsp_path_length, rsp_is_last};
            if (pending_rsp.size() == 0) report("unexpected", got, got);
            else begin
               rsp_type want;
               want = pending_rsp.pop_front();
               if (got.status !== want.status) report("status", got, want);
               if (got.vertex !== want.vertex) report("vertex", got, want);
               if (got.position !== want.position) report("position", got, want);
               if (got.path_length !== want.path_length) report("path_length", got, want);
               if (got.is_last !== want.is_last) report("is_last", got, want);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (fast_side) rsp_ready <= 1'b1;
         else if ($urandom_range(0, 29) == 0) begin
            hold_cycles = $urandom_range(10, 50);
            rsp_ready <= 1'b0;
         end else rsp_ready <= $urandom_range(0, 3) != 0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_directed();
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
      send_req(REQ_PATH_SRC, 3, 0, 0);
      send_req(REQ_ADD, 0, 15, 16'hFFFF);
      send_req(REQ_ADD, 15, 0, 16'h0001);
      send_req(REQ_ADD, 15, 1, 16'hFFFF);
      send_req(REQ_ADD, 0, 15, 16'h1234);
      send_req(REQ_ADD, 4, 4, 16'h0005);
      send_req(REQ_ADD, 2, 3, 16'h0000);
      send_req(REQ_REMOVE, 2, 3, 0);
      send_req(REQ_REMOVE, 7, 7, 0);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
      send_req(REQ_PATH_SRC, 15, 0, 0);
      send_req(REQ_REMOVE, 15, 0, 0);
      send_req(REQ_ADD, 1, 2, 16'h8000);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
      send_req(REQ_PATH_SRC, 0, 0, 0);
      send_req(REQ_PATH_SRC, 5, 0, 0);
      send_req(REQ_BAD_LO, 1, 2, 3);
      send_req(REQ_BAD_MID, 0, 0, 0);
      send_req(REQ_BAD_HI, 15, 15, 16'hFFFF);
   endtask

   task automatic test_vertex_count();
      write_count(5'd3);
      send_req(REQ_ADD, 3, 1, 16'h0010);
      send_req(REQ_ADD, 1, 0, 16'h0010);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
      send_req(REQ_PATH_SRC, 3, 0, 0);
      send_req(REQ_PATH_SRC, 1, 0, 0);
      send_req(REQ_REMOVE, 0, 15, 0);
      write_count(5'd1);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
      send_req(REQ_ADD, 0, 1, 16'h0001);
      write_count(5'd0);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH_SRC, 0, 0, 0);
      write_count(5'd31);
      send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
   endtask

   task automatic random_phase(int items, int maxv);
      int n, u, v, r;
      n = live_count();
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         u = $urandom_range(0, maxv);
         v = $urandom_range(0, maxv);
         if (r < 50) begin
            if (u > v) begin
               int t;
               t = u;
               u = v;
               v = t;
            end
            if ($urandom_range(0, 9) == 0) send_req(REQ_ADD, v, u, WIN_W'($urandom));
            else send_req(REQ_ADD, u, v,
                          $urandom_range(0, 9) == 0 ? 16'h0 : WIN_W'($urandom));
         end else if (r < 62) send_req(REQ_REMOVE, u, v, WIN_W'($urandom));
         else if (r < 75) send_req(REQ_SORT, u, v, WIN_W'($urandom));
         else if (r < 85) send_req(REQ_PATH, u, v, WIN_W'($urandom));
         else if (r < 96) send_req(REQ_PATH_SRC, $urandom_range(0, n - 1), v,
                                   WIN_W'($urandom));
         else send_req(REQ_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                       $urandom_range(0, 15), WIN_W'($urandom));
      end
   endtask

   task automatic test_random();
      write_count(5'd16);
      random_phase(90, 15);
      write_count(5'd6);
      random_phase(50, 7);
      write_count(5'd2);
      random_phase(25, 2);
      write_count(5'd11);
      random_phase(60, 12);
      fast_side = 1'b1;
      write_count(5'd16);
      random_phase(40, 15);
      fast_side = 1'b0;
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 1500;
      for (int i = 0; i < 6; i++) send_req(REQ_SORT, 0, 0, 0);
      send_req(REQ_PATH, 0, 0, 0);
   endtask

   initial begin
      vcount = VC_RESET;
      link_total = 0;
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 16; j++) graph_wt[i][j] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_vertex_count();
      test_random();
      test_backpressure();
      drain();
      repeat (50) @(posedge clock);
      if (err_count == 0 && pending_rsp.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
